@@ hw/rtl/pvt_pkg.sv @@
// package for the perspective vertex transform block
// holds the controller state type, command and status structs, register indexes and reciprocal seed table
package pvt_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_ROW,
		ST_NORM,
		ST_SEED,
		ST_R3,
		ST_RECIP,
		ST_QUOT,
		ST_PROJ,
		ST_PACK,
		ST_OUT
	} pvt_state_t;

	// register indexes on the configuration port
	localparam logic [2:0] REG_ROW0 = 3'd0;
	localparam logic [2:0] REG_ROW1 = 3'd1;
	localparam logic [2:0] REG_ROW2 = 3'd2;
	localparam logic [2:0] REG_HDIST = 3'd3;
	localparam logic [2:0] REG_OFFX = 3'd4;
	localparam logic [2:0] REG_OFFY = 3'd5;

	typedef struct packed {
		logic       load;
		logic       mac;
		logic [1:0] row;
		logic [1:0] term;
		logic       row_done;
		logic       norm_step;
		logic       seed;
		logic       r3;
		logic       recip;
		logic       quot;
		logic       proj;
		logic       pack;
	} pvt_cmd_t;

	typedef struct packed {
		logic norm_done;
	} pvt_status_t;

	function automatic logic [7:0] recip_seed(input logic [8:0] idx);
		logic [7:0] v;
		if (idx < 9'd8) v = 8'hff - {idx[6:0], 1'b0};
		else begin
			// 0x20000/(0x100+i) rounded, less 0x101, with the last entry held at zero
			case (idx)
				default: v = seed_lut(idx);
			endcase
		end
		return v;
	endfunction

	function automatic logic [7:0] seed_lut(input logic [8:0] i);
		logic [7:0] t [0:256];
		t = '{
		8'hff,8'hfd,8'hfb,8'hf9,8'hf7,8'hf5,8'hf3,8'hf1,8'hef,8'hee,8'hec,8'hea,8'he8,8'he6,8'he4,8'he3,
		8'he1,8'hdf,8'hdd,8'hdc,8'hda,8'hd8,8'hd6,8'hd5,8'hd3,8'hd1,8'hd0,8'hce,8'hcd,8'hcb,8'hc9,8'hc8,
		8'hc6,8'hc5,8'hc3,8'hc1,8'hc0,8'hbe,8'hbd,8'hbb,8'hba,8'hb8,8'hb7,8'hb5,8'hb4,8'hb2,8'hb1,8'hb0,
		8'hae,8'had,8'hab,8'haa,8'ha9,8'ha7,8'ha6,8'ha4,8'ha3,8'ha2,8'ha0,8'h9f,8'h9e,8'h9c,8'h9b,8'h9a,
		8'h99,8'h97,8'h96,8'h95,8'h94,8'h92,8'h91,8'h90,8'h8f,8'h8d,8'h8c,8'h8b,8'h8a,8'h89,8'h87,8'h86,
		8'h85,8'h84,8'h83,8'h82,8'h81,8'h7f,8'h7e,8'h7d,8'h7c,8'h7b,8'h7a,8'h79,8'h78,8'h77,8'h75,8'h74,
		8'h73,8'h72,8'h71,8'h70,8'h6f,8'h6e,8'h6d,8'h6c,8'h6b,8'h6a,8'h69,8'h68,8'h67,8'h66,8'h65,8'h64,
		8'h63,8'h62,8'h61,8'h60,8'h5f,8'h5e,8'h5d,8'h5d,8'h5c,8'h5b,8'h5a,8'h59,8'h58,8'h57,8'h56,8'h55,
		8'h54,8'h53,8'h53,8'h52,8'h51,8'h50,8'h4f,8'h4e,8'h4d,8'h4d,8'h4c,8'h4b,8'h4a,8'h49,8'h48,8'h48,
		8'h47,8'h46,8'h45,8'h44,8'h43,8'h43,8'h42,8'h41,8'h40,8'h3f,8'h3f,8'h3e,8'h3d,8'h3c,8'h3c,8'h3b,
		8'h3a,8'h39,8'h39,8'h38,8'h37,8'h36,8'h36,8'h35,8'h34,8'h33,8'h33,8'h32,8'h31,8'h31,8'h30,8'h2f,
		8'h2e,8'h2e,8'h2d,8'h2c,8'h2c,8'h2b,8'h2a,8'h2a,8'h29,8'h28,8'h28,8'h27,8'h26,8'h26,8'h25,8'h24,
		8'h24,8'h23,8'h22,8'h22,8'h21,8'h20,8'h20,8'h1f,8'h1e,8'h1e,8'h1d,8'h1d,8'h1c,8'h1b,8'h1b,8'h1a,
		8'h19,8'h19,8'h18,8'h18,8'h17,8'h16,8'h16,8'h15,8'h15,8'h14,8'h14,8'h13,8'h12,8'h12,8'h11,8'h11,
		8'h10,8'h0f,8'h0f,8'h0e,8'h0e,8'h0d,8'h0d,8'h0c,8'h0c,8'h0b,8'h0a,8'h0a,8'h09,8'h09,8'h08,8'h08,
		8'h07,8'h07,8'h06,8'h06,8'h05,8'h05,8'h04,8'h04,8'h03,8'h03,8'h02,8'h02,8'h01,8'h01,8'h00,8'h00,
		8'h00};
		return (i > 9'd256) ? 8'h00 : t[i];
	endfunction

endpackage

@@ hw/rtl/pvt_if.sv @@
// valid/ready channel interfaces for the vertex, result and config requests
// depends on nothing
interface pvt_vert_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] vert_x;
	logic signed [15:0] vert_y;
	logic signed [15:0] vert_z;
	logic signed [19:0] trans_x;
	logic signed [19:0] trans_y;
	logic signed [19:0] trans_z;
	modport source (output valid, vert_x, vert_y, vert_z, trans_x, trans_y, trans_z,
		input ready);
	modport sink (input valid, vert_x, vert_y, vert_z, trans_x, trans_y, trans_z,
		output ready);
endinterface

interface pvt_res_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] screen_x;
	logic signed [10:0] screen_y;
	logic [15:0]        depth;
	logic signed [15:0] view_x;
	logic signed [15:0] view_y;
	logic signed [15:0] view_z;
	logic [15:0]        depth_older0;
	logic [15:0]        depth_older1;
	logic [15:0]        depth_older2;
	logic [31:0]        point_older0;
	logic [31:0]        point_older1;
	modport source (output valid, screen_x, screen_y, depth, view_x, view_y, view_z,
		depth_older0, depth_older1, depth_older2, point_older0, point_older1, input ready);
	modport sink (input valid, screen_x, screen_y, depth, view_x, view_y, view_z,
		depth_older0, depth_older1, depth_older2, point_older0, point_older1, output ready);
endinterface

interface pvt_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/perspective_vertex_transform_top.sv @@
// per vertex, from request accept to result valid: multiply-accumulate and row steps on the
// shared multiplier, normalize steps set by the depth's leading zeros or cut short by a divide
// overflow, then seed, two refinements, quotient, proj, pack
// one vertex at a time: a new request is accepted only after the previous result is taken
// arst_n clears the state machine, the config registers and both fifos to zero
// depends on pvt_pkg, pvt_if, pvt_ctrl, pvt_dp
module perspective_vertex_transform_top (
	input logic clk,
	input logic arst_n,
	pvt_vert_if.sink   vert,
	pvt_res_if.source  res,
	pvt_cfg_if.sink    cfg
);
	import pvt_pkg::*;

	// configuration registers
	logic [47:0] row0_q, row1_q, row2_q;
	logic [15:0] hdist_q;
	logic [10:0] offx_q, offy_q;

	pvt_cmd_t    cmd;
	pvt_status_t status;
	logic [15:0] dfifo [4];
	logic [31:0] pfifo [2];

	// config writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= '0;
			row1_q <= '0;
			row2_q <= '0;
			hdist_q <= '0;
			offx_q <= '0;
			offy_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ROW0:  row0_q <= cfg.data;
				REG_ROW1:  row1_q <= cfg.data;
				REG_ROW2:  row2_q <= cfg.data;
				REG_HDIST: hdist_q <= cfg.data[15:0];
				REG_OFFX:  offx_q <= cfg.data[10:0];
				REG_OFFY:  offy_q <= cfg.data[10:0];
				default: ;
			endcase
		end
	end

	// sequencer
	pvt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vert.valid), .in_ready(vert.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.status(status), .cmd(cmd)
	);

	// arithmetic and fifo state
	pvt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.in_vx(vert.vert_x), .in_vy(vert.vert_y), .in_vz(vert.vert_z),
		.in_tx(vert.trans_x), .in_ty(vert.trans_y), .in_tz(vert.trans_z),
		.row0(row0_q), .row1(row1_q), .row2(row2_q),
		.hdist(hdist_q), .offx(offx_q), .offy(offy_q),
		.sx_o(res.screen_x), .sy_o(res.screen_y),
		.ir1_o(res.view_x), .ir2_o(res.view_y), .ir3_o(res.view_z),
		.dfifo_o(dfifo), .pfifo_o(pfifo)
	);

	assign res.depth = dfifo[3];
	assign res.depth_older0 = dfifo[0];
	assign res.depth_older1 = dfifo[1];
	assign res.depth_older2 = dfifo[2];
	assign res.point_older0 = pfifo[0];
	assign res.point_older1 = pfifo[1];

	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> $stable(res.view_x) && $stable(res.depth))
		else $error("result changed while stalled");
endmodule

@@ hw/rtl/pvt_ctrl.sv @@
// controller state machine sequencing the shared multiplier
// depends on pvt_pkg
module pvt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  pvt_pkg::pvt_status_t status,
	output pvt_pkg::pvt_cmd_t    cmd
);
	import pvt_pkg::*;

	pvt_state_t state_q, state_nx;
	logic [1:0] row_q, term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			term_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE) begin
				row_q <= '0;
				term_q <= '0;
			end else if (state_q == ST_MAC) begin
				term_q <= term_q + 2'd1;
			end else if (state_q == ST_ROW) begin
				term_q <= '0;
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nx = ST_MAC;
			ST_MAC:   if (term_q == 2'd2) state_nx = ST_ROW;
			ST_ROW:   state_nx = (row_q == 2'd2) ? ST_NORM : ST_MAC;
			ST_NORM:  if (status.norm_done) state_nx = ST_SEED;
			ST_SEED:  state_nx = ST_R3;
			ST_R3:    state_nx = ST_RECIP;
			ST_RECIP: state_nx = ST_QUOT;
			ST_QUOT:  state_nx = ST_PROJ;
			ST_PROJ:  state_nx = ST_PACK;
			ST_PACK:  state_nx = ST_OUT;
			ST_OUT:   if (out_ready) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.row = row_q;
		cmd.term = term_q;
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.mac = (state_q == ST_MAC);
		cmd.row_done = (state_q == ST_ROW);
		cmd.norm_step = (state_q == ST_NORM);
		cmd.seed = (state_q == ST_SEED);
		cmd.r3 = (state_q == ST_R3);
		cmd.recip = (state_q == ST_RECIP);
		cmd.quot = (state_q == ST_QUOT);
		cmd.proj = (state_q == ST_PROJ);
		cmd.pack = (state_q == ST_PACK);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_ready) |=> state_q == ST_OUT)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> term_q != 2'd3)
		else $error("term counter overran");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("accept while result pending");
endmodule

@@ hw/rtl/pvt_dp.sv @@
// datapath: shared multiplier, accumulator, normalizer, fifos and result register
// depends on pvt_pkg
module pvt_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pvt_pkg::pvt_cmd_t    cmd,
	output pvt_pkg::pvt_status_t status,
	input  logic [15:0]         in_vx,
	input  logic [15:0]         in_vy,
	input  logic [15:0]         in_vz,
	input  logic [19:0]         in_tx,
	input  logic [19:0]         in_ty,
	input  logic [19:0]         in_tz,
	input  logic [47:0]         row0,
	input  logic [47:0]         row1,
	input  logic [47:0]         row2,
	input  logic [15:0]         hdist,
	input  logic [10:0]         offx,
	input  logic [10:0]         offy,
	output logic [10:0]         sx_o,
	output logic [10:0]         sy_o,
	output logic [15:0]         ir1_o,
	output logic [15:0]         ir2_o,
	output logic [15:0]         ir3_o,
	output logic [15:0]         dfifo_o [4],
	output logic [31:0]         pfifo_o [2]
);
	import pvt_pkg::*;

	logic signed [15:0] v_q [3];
	logic signed [19:0] t_q [3];
	logic signed [47:0] acc_q;
	logic signed [15:0] ir_q [3];
	logic [15:0]        dfifo_q [4];
	logic [31:0]        pfifo_q [3];
	logic [15:0]        dn_q;
	logic [3:0]         sh_q;
	logic               ovf_q;
	logic [16:0]        r2_q;
	logic [16:0]        r3_q;
	logic [17:0]        recip_q;
	logic [16:0]        q_q;
	logic signed [10:0] sx_q, sy_q;

	logic [47:0]        row_sel;
	logic signed [15:0] coef;
	logic signed [31:0] prod;
	logic signed [47:0] fsum, shifted;
	logic signed [15:0] clamp16;
	logic [15:0]        dclamp;
	logic [14:0]        r1;
	logic [8:0]         sidx;
	logic [33:0]        r3mul;
	logic [16:0]        r3val;
	logic [33:0]        rcmul;
	logic [49:0]        qmul;
	logic [33:0]        qshift;
	logic signed [33:0] pxm, pym;
	logic signed [33:0] px, py;
	logic signed [10:0] cx, cy;

	always_comb begin
		unique case (cmd.row)
			2'd0: row_sel = row0;
			2'd1: row_sel = row1;
			default: row_sel = row2;
		endcase
		unique case (cmd.term)
			2'd0: coef = row_sel[15:0];
			2'd1: coef = row_sel[31:16];
			default: coef = row_sel[47:32];
		endcase
		prod = coef * v_q[cmd.term];
		fsum = acc_q + 48'(prod);
		shifted = acc_q >>> 12;
		if (shifted > 48'sh7FFF) clamp16 = 16'sh7FFF;
		else if (shifted < -48'sh8000) clamp16 = -16'sh8000;
		else clamp16 = shifted[15:0];
		if (shifted < 0) dclamp = '0;
		else if (shifted > 48'shFFFF) dclamp = 16'hFFFF;
		else dclamp = shifted[15:0];
		r1 = dn_q[14:0];
		sidx = 9'((({2'b0, r1} + 17'h40) >> 7) & 17'h1ff);
		r3mul = 34'(r2_q) * 34'({2'b0, r1} + 17'h8000);
		r3val = 17'((34'h80 - r3mul) >> 8);
		rcmul = 34'(r2_q) * 34'(r3_q) + 34'h80;
		qmul = 50'(recip_q) * (50'(hdist) << sh_q) + 50'h8000;
		qshift = qmul[49:16];
		pxm = $signed(ir_q[0]) * $signed({1'b0, q_q});
		pym = $signed(ir_q[1]) * $signed({1'b0, q_q});
		px = (pxm + (34'($signed(offx)) <<< 16)) >>> 16;
		py = (pym + (34'($signed(offy)) <<< 16)) >>> 16;
		cx = (px > 34'sh3FF) ? 11'sh3FF : (px < -34'sh400) ? -11'sh400 : px[10:0];
		cy = (py > 34'sh3FF) ? 11'sh3FF : (py < -34'sh400) ? -11'sh400 : py[10:0];
	end

	assign status.norm_done = ovf_q || dn_q[15];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q[0] <= in_vx;
			v_q[1] <= in_vy;
			v_q[2] <= in_vz;
			t_q[0] <= in_tx;
			t_q[1] <= in_ty;
			t_q[2] <= in_tz;
			acc_q <= 48'($signed(in_tx)) <<< 12;
		end else if (cmd.mac) begin
			acc_q <= fsum;
		end else if (cmd.row_done) begin
			ir_q[cmd.row] <= clamp16;
			if (cmd.row != 2'd2) acc_q <= 48'(t_q[cmd.row + 2'd1]) <<< 12;
			else begin
				dn_q <= dclamp;
				sh_q <= '0;
				ovf_q <= {1'b0, hdist} >= {dclamp, 1'b0};
			end
		end else if (cmd.norm_step) begin
			if (!status.norm_done) begin
				dn_q <= dn_q << 1;
				sh_q <= sh_q + 4'd1;
			end
		end
		if (cmd.seed) r2_q <= 17'(recip_seed(sidx)) + 17'h101;
		if (cmd.r3) r3_q <= r3val;
		if (cmd.recip) recip_q <= 18'(rcmul >> 8);
		if (cmd.quot) q_q <= ovf_q ? 17'h1FFFF : (qshift > 34'h1FFFF) ? 17'h1FFFF : qshift[16:0];
		if (cmd.proj) begin
			sx_q <= cx;
			sy_q <= cy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) dfifo_q[i] <= '0;
			for (int i = 0; i < 3; i++) pfifo_q[i] <= '0;
		end else begin
			if (cmd.row_done && cmd.row == 2'd2) begin
				dfifo_q[0] <= dfifo_q[1];
				dfifo_q[1] <= dfifo_q[2];
				dfifo_q[2] <= dfifo_q[3];
				dfifo_q[3] <= dclamp;
			end
			if (cmd.pack) begin
				pfifo_q[0] <= pfifo_q[1];
				pfifo_q[1] <= pfifo_q[2];
				pfifo_q[2] <= {{5{sy_q[10]}}, sy_q, {5{sx_q[10]}}, sx_q};
			end
		end
	end

	assign sx_o = sx_q;
	assign sy_o = sy_q;
	assign ir1_o = ir_q[0];
	assign ir2_o = ir_q[1];
	assign ir3_o = ir_q[2];
	assign dfifo_o = dfifo_q;
	assign pfifo_o[0] = pfifo_q[0];
	assign pfifo_o[1] = pfifo_q[1];

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.quot && ovf_q |=> q_q == 17'h1FFFF)
		else $error("overflow quotient not saturated");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seed |-> (ovf_q || dn_q[15]))
		else $error("divisor not normalized");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.proj |=> (sx_q <= 11'sh3FF))
		else $error("screen x out of range");
endmodule

@@ verif/pvt_scoreboard.sv @@
// scoreboard for the perspective vertex transform: predicts each projected vertex
// from the register copy and both fifo copies; depends on pvt_pkg
package pvt_scoreboard;

	typedef struct packed {
		logic [10:0] screen_x;
		logic [10:0] screen_y;
		logic [15:0] depth;
		logic [15:0] view_x;
		logic [15:0] view_y;
		logic [15:0] view_z;
		logic [15:0] depth_older0;
		logic [15:0] depth_older1;
		logic [15:0] depth_older2;
		logic [31:0] point_older0;
		logic [31:0] point_older1;
	} proj_vertex_t;

class vertex_sb_t;
	logic [47:0] rot_row [3];
	logic [15:0] hdist;
	logic [10:0] offx, offy;
	logic [15:0] depth_hist [4];
	logic [31:0] point_hist [3];
	proj_vertex_t pending [$];
	int mismatches;
	int checked;
	int overflow_divides;

	function new();
		foreach (rot_row[i]) rot_row[i] = '0;
		foreach (depth_hist[i]) depth_hist[i] = '0;
		foreach (point_hist[i]) point_hist[i] = '0;
		hdist = '0;
		offx = '0;
		offy = '0;
		mismatches = 0;
		checked = 0;
		overflow_divides = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [47:0] val);
		case (idx)
			pvt_pkg::REG_ROW0: rot_row[0] = val;
			pvt_pkg::REG_ROW1: rot_row[1] = val;
			pvt_pkg::REG_ROW2: rot_row[2] = val;
			pvt_pkg::REG_HDIST: hdist = val[15:0];
			pvt_pkg::REG_OFFX: offx = val[10:0];
			pvt_pkg::REG_OFFY: offy = val[10:0];
			default: ;
		endcase
	endfunction

	static function logic [7:0] seed_of(int i);
		logic [7:0] t [0:256];
		t = '{
		8'hff,8'hfd,8'hfb,8'hf9,8'hf7,8'hf5,8'hf3,8'hf1,8'hef,8'hee,8'hec,8'hea,8'he8,8'he6,8'he4,8'he3,
		8'he1,8'hdf,8'hdd,8'hdc,8'hda,8'hd8,8'hd6,8'hd5,8'hd3,8'hd1,8'hd0,8'hce,8'hcd,8'hcb,8'hc9,8'hc8,
		8'hc6,8'hc5,8'hc3,8'hc1,8'hc0,8'hbe,8'hbd,8'hbb,8'hba,8'hb8,8'hb7,8'hb5,8'hb4,8'hb2,8'hb1,8'hb0,
		8'hae,8'had,8'hab,8'haa,8'ha9,8'ha7,8'ha6,8'ha4,8'ha3,8'ha2,8'ha0,8'h9f,8'h9e,8'h9c,8'h9b,8'h9a,
		8'h99,8'h97,8'h96,8'h95,8'h94,8'h92,8'h91,8'h90,8'h8f,8'h8d,8'h8c,8'h8b,8'h8a,8'h89,8'h87,8'h86,
		8'h85,8'h84,8'h83,8'h82,8'h81,8'h7f,8'h7e,8'h7d,8'h7c,8'h7b,8'h7a,8'h79,8'h78,8'h77,8'h75,8'h74,
		8'h73,8'h72,8'h71,8'h70,8'h6f,8'h6e,8'h6d,8'h6c,8'h6b,8'h6a,8'h69,8'h68,8'h67,8'h66,8'h65,8'h64,
		8'h63,8'h62,8'h61,8'h60,8'h5f,8'h5e,8'h5d,8'h5d,8'h5c,8'h5b,8'h5a,8'h59,8'h58,8'h57,8'h56,8'h55,
		8'h54,8'h53,8'h53,8'h52,8'h51,8'h50,8'h4f,8'h4e,8'h4d,8'h4d,8'h4c,8'h4b,8'h4a,8'h49,8'h48,8'h48,
		8'h47,8'h46,8'h45,8'h44,8'h43,8'h43,8'h42,8'h41,8'h40,8'h3f,8'h3f,8'h3e,8'h3d,8'h3c,8'h3c,8'h3b,
		8'h3a,8'h39,8'h39,8'h38,8'h37,8'h36,8'h36,8'h35,8'h34,8'h33,8'h33,8'h32,8'h31,8'h31,8'h30,8'h2f,
		8'h2e,8'h2e,8'h2d,8'h2c,8'h2c,8'h2b,8'h2a,8'h2a,8'h29,8'h28,8'h28,8'h27,8'h26,8'h26,8'h25,8'h24,
		8'h24,8'h23,8'h22,8'h22,8'h21,8'h20,8'h20,8'h1f,8'h1e,8'h1e,8'h1d,8'h1d,8'h1c,8'h1b,8'h1b,8'h1a,
		8'h19,8'h19,8'h18,8'h18,8'h17,8'h16,8'h16,8'h15,8'h15,8'h14,8'h14,8'h13,8'h12,8'h12,8'h11,8'h11,
		8'h10,8'h0f,8'h0f,8'h0e,8'h0e,8'h0d,8'h0d,8'h0c,8'h0c,8'h0b,8'h0a,8'h0a,8'h09,8'h09,8'h08,8'h08,
		8'h07,8'h07,8'h06,8'h06,8'h05,8'h05,8'h04,8'h04,8'h03,8'h03,8'h02,8'h02,8'h01,8'h01,8'h00,8'h00,
		8'h00};
		return t[i];
	endfunction

	static function longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// arithmetic shift rounds toward minus infinity, as the hardware does
	function longint rotate_row(int r, longint t, longint x, longint y, longint z);
		longint acc;
		acc = t * 4096
			+ longint'($signed(rot_row[r][15:0])) * x
			+ longint'($signed(rot_row[r][31:16])) * y
			+ longint'($signed(rot_row[r][47:32])) * z;
		return acc >>> 12;
	endfunction

	function logic [16:0] reciprocal_quotient(logic [15:0] d);
		int sh;
		logic [31:0] r1, r2, r3, recip, dn;
		logic [63:0] q;
		if ({16'd0, hdist} >= {15'd0, d, 1'b0}) begin
			overflow_divides++;
			return 17'h1FFFF;
		end
		sh = 0;
		while ((({16'd0, d} << sh) & 32'h8000) == 0) sh++;
		dn = {16'd0, d} << sh;
		r1 = dn & 32'h7fff;
		r2 = 32'(seed_of(((r1 + 32'h40) >> 7) & 32'h1ff)) + 32'h101;
		r3 = ((32'h80 - r2 * (r1 + 32'h8000)) >> 8) & 32'h1ffff;
		recip = (r2 * r3 + 32'h80) >> 8;
		q = (64'(recip) * (64'(hdist) << sh) + 64'h8000) >> 16;
		return (q > 64'h1FFFF) ? 17'h1FFFF : q[16:0];
	endfunction

	function void note_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
		logic [19:0] tx, logic [19:0] ty, logic [19:0] tz);
		longint m1, m2, m3, ir1, ir2, ir3, sx, sy;
		logic [16:0] q;
		proj_vertex_t e;
		m1 = rotate_row(0, $signed(tx), $signed(vx), $signed(vy), $signed(vz));
		m2 = rotate_row(1, $signed(ty), $signed(vx), $signed(vy), $signed(vz));
		m3 = rotate_row(2, $signed(tz), $signed(vx), $signed(vy), $signed(vz));
		ir1 = clip(m1, -32768, 32767);
		ir2 = clip(m2, -32768, 32767);
		ir3 = clip(m3, -32768, 32767);
		depth_hist[0] = depth_hist[1];
		depth_hist[1] = depth_hist[2];
		depth_hist[2] = depth_hist[3];
		depth_hist[3] = 16'(clip(m3, 0, 65535));
		q = reciprocal_quotient(depth_hist[3]);
		sx = (longint'($signed(offx)) * 65536 + ir1 * longint'(q)) >>> 16;
		sy = (longint'($signed(offy)) * 65536 + ir2 * longint'(q)) >>> 16;
		sx = clip(sx, -1024, 1023);
		sy = clip(sy, -1024, 1023);
		point_hist[0] = point_hist[1];
		point_hist[1] = point_hist[2];
		point_hist[2] = {sy[15:0], sx[15:0]};
		e.screen_x = sx[10:0];
		e.screen_y = sy[10:0];
		e.depth = depth_hist[3];
		e.view_x = ir1[15:0];
		e.view_y = ir2[15:0];
		e.view_z = ir3[15:0];
		e.depth_older0 = depth_hist[0];
		e.depth_older1 = depth_hist[1];
		e.depth_older2 = depth_hist[2];
		e.point_older0 = point_hist[0];
		e.point_older1 = point_hist[1];
		pending.push_back(e);
	endfunction

	function void check_result(proj_vertex_t got);
		proj_vertex_t e;
		checked++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result with nothing pending");
			return;
		end
		e = pending.pop_front();
		if (got !== e) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch at result %0d", checked);
				$display("  exp sx=%h sy=%h d=%h v=%h,%h,%h dq=%h,%h,%h p=%h,%h",
					e.screen_x, e.screen_y, e.depth, e.view_x, e.view_y, e.view_z,
					e.depth_older0, e.depth_older1, e.depth_older2,
					e.point_older0, e.point_older1);
				$display("  got sx=%h sy=%h d=%h v=%h,%h,%h dq=%h,%h,%h p=%h,%h",
					got.screen_x, got.screen_y, got.depth, got.view_x, got.view_y,
					got.view_z, got.depth_older0, got.depth_older1, got.depth_older2,
					got.point_older0, got.point_older1);
			end
		end
	endfunction
endclass

endpackage

@@ verif/tb_perspective_vertex_transform_top.sv @@
// testbench for perspective_vertex_transform_top: directed and random vertices,
// several register settings and idle phases, checked by pvt_scoreboard
// depends on pvt_pkg, pvt_if, the block's rtl and verif/pvt_scoreboard.sv
module tb_perspective_vertex_transform_top;
	import pvt_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pvt_vert_if vert ();
	pvt_res_if  res ();
	pvt_cfg_if  cfg ();

	perspective_vertex_transform_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vert   (vert.sink),
		.res    (res.source),
		.cfg    (cfg.sink)
	);

	pvt_scoreboard::vertex_sb_t sb = new();

	// idle odds in percent, changed per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// long receiver hold-off, counted down in the sink process
	int hold_off_cycles = 0;
	int cycle_count = 0;
	int vertices_sent = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		vert.valid = 1'b0;
		vert.vert_x = '0;
		vert.vert_y = '0;
		vert.vert_z = '0;
		vert.trans_x = '0;
		vert.trans_y = '0;
		vert.trans_z = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		res.ready = 1'b0;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_perspective_vertex_transform_top: done, errors");
			$finish;
		end
	end

	// result sink: random stalls, long hold-off, compare on each accepted result
	always @(posedge clk) begin
		pvt_scoreboard::proj_vertex_t got;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				got.screen_x = res.screen_x;
				got.screen_y = res.screen_y;
				got.depth = res.depth;
				got.view_x = res.view_x;
				got.view_y = res.view_y;
				got.view_z = res.view_z;
				got.depth_older0 = res.depth_older0;
				got.depth_older1 = res.depth_older1;
				got.depth_older2 = res.depth_older2;
				got.point_older0 = res.point_older0;
				got.point_older1 = res.point_older1;
				sb.check_result(got);
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		cfg.index <= idx;
		cfg.data <= val;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// offer one vertex request, hold it until taken
	task automatic send_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
		logic [19:0] tx, logic [19:0] ty, logic [19:0] tz);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		vert.vert_x <= vx;
		vert.vert_y <= vy;
		vert.vert_z <= vz;
		vert.trans_x <= tx;
		vert.trans_y <= ty;
		vert.trans_z <= tz;
		vert.valid <= 1'b1;
		@(posedge clk);
		while (!vert.ready) @(posedge clk);
		sb.note_vertex(vx, vy, vz, tx, ty, tz);
		vertices_sent++;
		vert.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every pending result, then let the pipe settle
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// coefficient mostly within unity scale so projections land on screen
	function automatic logic [15:0] rand_coef();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(8192)) - 4096);
			default: return 16'($signed($urandom_range(1024)) - 512);
		endcase
	endfunction

	task automatic random_setting(bit extreme);
		logic [47:0] row;
		for (int r = 0; r < 3; r++) begin
			if (extreme) row = {3{($urandom_range(1) ? 16'h8000 : 16'h7fff)}};
			else row = {rand_coef(), rand_coef(), rand_coef()};
			write_reg(3'(r), row);
		end
		write_reg(REG_HDIST, extreme ? ($urandom_range(1) ? 48'hffff : 48'h0)
			: 48'($urandom_range(65535)));
		write_reg(REG_OFFX, 48'($urandom_range(2047)));
		write_reg(REG_OFFY, 48'($urandom_range(2047)));
	endtask

	// random vertex: mostly moderate coordinates with a positive depth push
	task automatic random_vertex();
		logic [15:0] vx, vy, vz;
		logic [19:0] tx, ty, tz;
		if ($urandom_range(9) < 2) begin
			vx = 16'($urandom); vy = 16'($urandom); vz = 16'($urandom);
			tx = 20'($urandom); ty = 20'($urandom); tz = 20'($urandom);
		end else begin
			vx = 16'($signed($urandom_range(4000)) - 2000);
			vy = 16'($signed($urandom_range(4000)) - 2000);
			vz = 16'($signed($urandom_range(4000)) - 2000);
			tx = 20'($signed($urandom_range(2000)) - 1000);
			ty = 20'($signed($urandom_range(2000)) - 1000);
			tz = 20'($urandom_range(30000));
		end
		send_vertex(vx, vy, vz, tx, ty, tz);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity rotation, moderate distance, offsets of -1 in x and 1023 in y
		write_reg(REG_ROW0, {16'h0, 16'h0, 16'h1000});
		write_reg(REG_ROW1, {16'h0, 16'h1000, 16'h0});
		write_reg(REG_ROW2, {16'h1000, 16'h0, 16'h0});
		write_reg(REG_HDIST, 48'd200);
		write_reg(REG_OFFX, 48'h7ff);
		write_reg(REG_OFFY, 48'h3ff);

		// directed: field extremes, zero depth, divide overflow, clamps
		send_vertex(16'h0, 16'h0, 16'h0, 20'h0, 20'h0, 20'h0);
		send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 20'h7ffff, 20'h7ffff, 20'h7ffff);
		send_vertex(16'h8000, 16'h8000, 16'h8000, 20'h80000, 20'h80000, 20'h80000);
		send_vertex(16'h7fff, 16'h8000, 16'h0064, 20'h0, 20'h0, 20'h0);
		send_vertex(16'h0064, 16'hff9c, 16'h0050, 20'h0, 20'h0, 20'h0);
		send_vertex(16'h0001, 16'h0001, 16'h0001, 20'h0, 20'h0, 20'h0);
		send_vertex(16'hffff, 16'hffff, 16'hffff, 20'hfffff, 20'hfffff, 20'hfffff);
		send_vertex(16'h1234, 16'hedcb, 16'h4000, 20'h00100, 20'hfff00, 20'h01000);
		// triangle: three in a row
		send_vertex(16'h0100, 16'h0000, 16'h0200, 20'h0, 20'h0, 20'h00800);
		send_vertex(16'h0000, 16'h0100, 16'h0400, 20'h0, 20'h0, 20'h00800);
		send_vertex(16'hff00, 16'hff00, 16'h7000, 20'h0, 20'h0, 20'h00800);
		drain();

		// extreme settings, overflow paths and unknown index
		write_reg(3'd6, 48'hffffffffffff);
		write_reg(3'd7, 48'h123456789abc);
		write_reg(REG_ROW0, 48'h7fff80007fff);
		write_reg(REG_ROW1, 48'h80007fff8000);
		write_reg(REG_ROW2, 48'h800080008000);
		write_reg(REG_HDIST, 48'hffff);
		write_reg(REG_OFFX, 48'h400);
		write_reg(REG_OFFY, 48'h400);
		send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 20'h7ffff, 20'h7ffff, 20'h80000);
		send_vertex(16'h8000, 16'h8000, 16'h8000, 20'h80000, 20'h80000, 20'h7ffff);
		send_vertex(16'h8000, 16'h7fff, 16'h8000, 20'h0, 20'h0, 20'h0);
		send_vertex(16'h0001, 16'hffff, 16'h8000, 20'h12345, 20'hedcba, 20'h7ffff);
		drain();

		// random phases: no idling, sender idle, receiver stall, both
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 68; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 68; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			random_setting(ph == 3 || ph == 7);
			// long receiver hold-off while the sender keeps offering
			if (ph == 4) hold_off_cycles = 400;
			repeat (172) random_vertex();
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		$display("covered %0d vertices over ten register settings and four idle mixes",
			vertices_sent);
		$display("%0d results checked, %0d saturated divides predicted",
			sb.checked, sb.overflow_divides);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb_perspective_vertex_transform_top: done, clean");
		else
			$display("tb_perspective_vertex_transform_top: done, errors");
		$finish;
	end
endmodule
